@@ sv/ffha_pkg.sv @@
// Shared types and constants for the first-fit heap allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffha_pkg;
  localparam int ADDR_W = 21;
  localparam int SIZE_W = 22;
  localparam int STATUS_W = 2;
  localparam int MIN_SPLIT = 16;

  localparam logic [STATUS_W-1:0] ST_OK = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OOM = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BADADDR = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_RELEASE = 1'b1;
endpackage
`default_nettype wire

@@ sv/ffha_table.sv @@
// Segment table storage: one memory holding start, size and free mark per entry, plus segment count.
`timescale 1ns / 1ps
`default_nettype none
module ffha_table
  import ffha_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   we,
  input  wire [IDX_W-1:0]       waddr,
  input  wire [SIZE_W-1:0]      wstart,
  input  wire [SIZE_W-1:0]      wsize,
  input  wire                   wfree,
  input  wire [IDX_W-1:0]       raddr,
  output logic [SIZE_W-1:0]     rstart,
  output logic [SIZE_W-1:0]     rsize,
  output logic                  rfree,
  input  wire                   cnt_inc,
  input  wire                   cnt_dec,
  output logic [CNT_W-1:0]      count
);
  logic [2*SIZE_W:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wstart, wsize, wfree};
    end
    {rstart, rsize, rfree} <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
    end else if (cnt_inc) begin
      count <= count + CNT_W'(1);
    end else if (cnt_dec) begin
      count <= count - CNT_W'(1);
    end
  end
endmodule
`default_nettype wire

@@ sv/ffha_ctrl.sv @@
// Sequencer: scans, shifts and merges table entries, handling one request at a time.
`timescale 1ns / 1ps
`default_nettype none
module ffha_ctrl
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES = 2097152,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_SEGMENTS = 64,
  parameter int IDX_W = 6,
  parameter int CNT_W = 7
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 kind,
  input  wire [SIZE_W-1:0]    request_size,
  input  wire [ADDR_W-1:0]    address,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [ADDR_W-1:0]   address_out,
  output logic [STATUS_W-1:0] status,
  output logic                we,
  output logic [IDX_W-1:0]    waddr,
  output logic [SIZE_W-1:0]   wstart,
  output logic [SIZE_W-1:0]   wsize,
  output logic                wfree,
  output logic [IDX_W-1:0]    raddr,
  input  wire [SIZE_W-1:0]    rstart,
  input  wire [SIZE_W-1:0]    rsize,
  input  wire                 rfree,
  output logic                cnt_inc,
  output logic                cnt_dec,
  input  wire [CNT_W-1:0]     count
);
  localparam int SW = SIZE_W + 2;
  localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);
  localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_SEGMENTS);

  typedef enum logic [12:0] {
    S_INIT   = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ARD    = 13'b0000000000100,
    S_ACHK   = 13'b0000000001000,
    S_SHRD   = 13'b0000000010000,
    S_SHWR   = 13'b0000000100000,
    S_SPLIT  = 13'b0000001000000,
    S_RRD    = 13'b0000010000000,
    S_RCHK   = 13'b0000100000000,
    S_MRD    = 13'b0001000000000,
    S_MLOAD  = 13'b0010000000000,
    S_MCHK   = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_t;

  state_t state;
  logic [CNT_W-1:0] idx, j, limit;
  logic [SW-1:0] want;
  logic [ADDR_W-1:0] rel_addr;
  logic [SIZE_W-1:0] hit_start, hit_size;
  logic [SIZE_W-1:0] a_start, a_size;
  logic a_free;

  logic [SW-1:0] rsize_x, rstart_x, merged_size;
  logic fits, split_ok, addr_hit;
  assign rsize_x = SW'(rsize);
  assign rstart_x = SW'(rstart);
  assign merged_size = SW'(a_size) + HDR + rsize_x;
  assign fits = rfree && (rsize_x >= want);
  assign split_ok = (rsize_x > want + HDR + SW'(MIN_SPLIT)) && (count < MAXC);
  assign addr_hit = (rstart_x + HDR == SW'(rel_addr));

  assign in_ready = (state == S_IDLE);

  // memory address and write data are combinational from state
  always_comb begin
    we = 1'b0;
    waddr = idx[IDX_W-1:0];
    wstart = rstart;
    wsize = rsize;
    wfree = rfree;
    raddr = idx[IDX_W-1:0];
    cnt_inc = 1'b0;
    cnt_dec = 1'b0;
    case (state)
      S_INIT: begin
        we = 1'b1;
        waddr = '0;
        wstart = '0;
        wsize = SIZE_W'(HEAP_BYTES - HEADER_BYTES);
        wfree = 1'b1;
      end
      S_ACHK: begin
        if (idx < count && fits) begin
          we = 1'b1;
          wfree = 1'b0;
          if (split_ok) begin
            wsize = SIZE_W'(want);
          end
        end
      end
      S_SHRD: raddr = IDX_W'(j - CNT_W'(1));
      S_SHWR: begin
        we = 1'b1;
        waddr = j[IDX_W-1:0];
        raddr = IDX_W'(j - CNT_W'(2));
      end
      S_SPLIT: begin
        we = 1'b1;
        waddr = IDX_W'(idx + CNT_W'(1));
        wstart = SIZE_W'(SW'(hit_start) + HDR + want);
        wsize = SIZE_W'(SW'(hit_size) - want - HDR);
        wfree = 1'b1;
        cnt_inc = 1'b1;
      end
      S_RCHK: begin
        if (idx < count && addr_hit) begin
          we = 1'b1;
          wfree = 1'b1;
        end
      end
      S_MRD: raddr = '0;
      S_MLOAD: raddr = j[IDX_W-1:0];
      S_MCHK: begin
        // a holds the entry kept at idx, read data is entry j
        raddr = IDX_W'(j + CNT_W'(1));
        if (j < limit && a_free && rfree) begin
          cnt_dec = 1'b1;
        end else begin
          we = 1'b1;
          waddr = idx[IDX_W-1:0];
          wstart = a_start;
          wsize = a_size;
          wfree = a_free;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (in_valid) begin
            want <= (SW'(request_size) + SW'(7)) & ~SW'(7);
            rel_addr <= address;
            idx <= '0;
            if (kind == KIND_ALLOC) begin
              state <= S_ARD;
            end else if (address == '0) begin
              address_out <= '0;
              status <= ST_OK;
              out_valid <= 1'b1;
              state <= S_OUT;
            end else begin
              state <= S_RRD;
            end
          end
        end
        S_ARD: state <= S_ACHK;
        S_ACHK: begin
          if (idx >= count) begin
            address_out <= '0;
            status <= ST_OOM;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (fits) begin
            address_out <= ADDR_W'(rstart_x + HDR);
            status <= ST_OK;
            hit_start <= rstart;
            hit_size <= rsize;
            if (split_ok) begin
              j <= count;
              if (count == idx + CNT_W'(1)) begin
                state <= S_SPLIT;
              end else begin
                state <= S_SHRD;
              end
            end else begin
              out_valid <= 1'b1;
              state <= S_OUT;
            end
          end else begin
            idx <= idx + CNT_W'(1);
            state <= S_ARD;
          end
        end
        S_SHRD: state <= S_SHWR;
        S_SHWR: begin
          j <= j - CNT_W'(1);
          if (j - CNT_W'(1) == idx + CNT_W'(1)) begin
            state <= S_SPLIT;
          end
        end
        S_SPLIT: begin
          out_valid <= 1'b1;
          state <= S_OUT;
        end
        S_RRD: state <= S_RCHK;
        S_RCHK: begin
          if (idx >= count) begin
            address_out <= '0;
            status <= ST_BADADDR;
            out_valid <= 1'b1;
            state <= S_OUT;
          end else if (addr_hit) begin
            address_out <= '0;
            status <= ST_OK;
            idx <= '0;
            j <= CNT_W'(1);
            limit <= count;
            state <= S_MRD;
          end else begin
            idx <= idx + CNT_W'(1);
            state <= S_RRD;
          end
        end
        S_MRD: state <= S_MLOAD;
        S_MLOAD: begin
          a_start <= rstart;
          a_size <= rsize;
          a_free <= rfree;
          state <= S_MCHK;
        end
        S_MCHK: begin
          if (j >= limit) begin
            out_valid <= 1'b1;
            state <= S_OUT;
          end else begin
            if (a_free && rfree) begin
              a_size <= SIZE_W'(merged_size);
            end else begin
              idx <= idx + CNT_W'(1);
              a_start <= rstart;
              a_size <= rsize;
              a_free <= rfree;
            end
            j <= j + CNT_W'(1);
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator.
//
//   channel   handshake             fields
//   request   in_valid / in_ready   kind, request_size, address
//   result    out_valid / out_ready address_out, status
//
// One transaction at a time; in_ready is high only while idle.
// Each table entry scanned takes a read state and a check state; a split also shifts later entries up.
// A matched release adds a merge pass over all entries that joins adjacent free ones.
// The result is held until out_ready is high.
// After reset, entry 0 is written as one free segment in S_INIT before in_ready rises.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_heap_allocator
  import ffha_pkg::*;
#(
  parameter int HEAP_BYTES = 2097152,
  parameter int HEADER_BYTES = 24,
  parameter int MAX_SEGMENTS = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire                 kind,
  input  wire [SIZE_W-1:0]    request_size,
  input  wire [ADDR_W-1:0]    address,
  output logic                out_valid,
  input  wire                 out_ready,
  output logic [ADDR_W-1:0]   address_out,
  output logic [STATUS_W-1:0] status
);
  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  logic we, wfree, rfree, cnt_inc, cnt_dec;
  logic [IDX_W-1:0] waddr, raddr;
  logic [SIZE_W-1:0] wstart, wsize, rstart, rsize;
  logic [CNT_W-1:0] count;

  ffha_ctrl #(
    .HEAP_BYTES(HEAP_BYTES), .HEADER_BYTES(HEADER_BYTES),
    .MAX_SEGMENTS(MAX_SEGMENTS), .IDX_W(IDX_W), .CNT_W(CNT_W)
  ) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .request_size(request_size), .address(address),
    .out_valid(out_valid), .out_ready(out_ready),
    .address_out(address_out), .status(status),
    .we(we), .waddr(waddr), .wstart(wstart), .wsize(wsize), .wfree(wfree),
    .raddr(raddr), .rstart(rstart), .rsize(rsize), .rfree(rfree),
    .cnt_inc(cnt_inc), .cnt_dec(cnt_dec), .count(count)
  );

  ffha_table #(
    .DEPTH(MAX_SEGMENTS), .IDX_W(IDX_W), .CNT_W(CNT_W)
  ) u_table (
    .clk(clk), .rst(rst), .we(we), .waddr(waddr), .wstart(wstart),
    .wsize(wsize), .wfree(wfree), .raddr(raddr), .rstart(rstart),
    .rsize(rsize), .rfree(rfree), .cnt_inc(cnt_inc), .cnt_dec(cnt_dec),
    .count(count)
  );

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(address_out) && $stable(status)));
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid));
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_OOM || status == ST_BADADDR));
  a_fail_null: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (address_out == '0));
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (count != '0) && (count <= CNT_W'(MAX_SEGMENTS)));
endmodule
`default_nettype wire
